### design/sli_pkg.sv
// sli_pkg: shared types for the sorted list block
// state, status and command codes, controller to datapath command and status words
// no dependencies
`default_nettype none

package sli_pkg;

    // operation carried in the input tuser
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    // result status carried in the output tuser
    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_HEAD,
        S_RESP
    } t_state;

    // source and target of a store write
    typedef enum logic [1:0] {
        WR_SHIFT_UP,   // entry moves one slot up
        WR_VAL_UP,     // new value lands above the compared entry
        WR_SHIFT_DN,   // entry moves one slot down over the removed one
        WR_VAL_HEAD    // new value lands in slot zero
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    set_found;
        logic    fill_inc;
        logic    fill_dec;
    } t_dp_ctl;

    typedef struct packed {
        logic is_rem;
        logic empty;
        logic full;
        logic rd_last;
        logic dat_last;
        logic gt;
        logic eq;
        logic found;
    } t_dp_sts;

endpackage

`default_nettype wire

### design/sli_dp.sv
// sli_dp: datapath of the sorted list, entry store, walk indices and fill count
// depends on sli_pkg
`default_nettype none

module sli_dp #(
    parameter int CAPACITY = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire sli_pkg::t_dp_ctl        i_ctl,
    input  wire                          i_cmd,
    input  wire [31:0]                   i_value,
    output sli_pkg::t_dp_sts             o_sts,
    output logic [$clog2(CAPACITY+1)-1:0] o_fill
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0]     mem [CAPACITY];
    logic [31:0]     r_rd_data;
    sli_pkg::t_cmd   r_cmd;
    logic [31:0]     r_val;
    logic [CW-1:0]   r_fill;
    logic [CW-1:0]   n_fill;
    logic [AW-1:0]   r_rd_idx;
    logic [AW-1:0]   r_dat_idx;
    logic            r_found;
    logic [AW-1:0]   fill_m1;
    logic [AW-1:0]   wr_addr;
    logic [31:0]     wr_data;
    logic            is_rem;

    assign is_rem  = (r_cmd == sli_pkg::CMD_REMOVE);
    assign fill_m1 = AW'(r_fill - CW'(1));

    // write address and data
    always_comb begin
        unique case (i_ctl.wr_sel)
            sli_pkg::WR_SHIFT_UP: begin
                wr_addr = r_dat_idx + AW'(1);
                wr_data = r_rd_data;
            end
            sli_pkg::WR_VAL_UP: begin
                wr_addr = r_dat_idx + AW'(1);
                wr_data = r_val;
            end
            sli_pkg::WR_SHIFT_DN: begin
                wr_addr = r_dat_idx - AW'(1);
                wr_data = r_rd_data;
            end
            default: begin
                wr_addr = '0;
                wr_data = r_val;
            end
        endcase
    end

    // entry store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[r_rd_idx];
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (i_ctl.fill_inc) begin
            n_fill = r_fill + CW'(1);
        end else if (i_ctl.fill_dec) begin
            n_fill = r_fill - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_found <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_ctl.load) begin
                r_found <= 1'b0;
            end else if (i_ctl.set_found) begin
                r_found <= 1'b1;
            end
        end
    end

    // command word and walk indices; insert walks down from the top, remove walks up
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= sli_pkg::t_cmd'(i_cmd);
            r_val    <= i_value;
            r_rd_idx <= (sli_pkg::t_cmd'(i_cmd) == sli_pkg::CMD_REMOVE) ? '0 : fill_m1;
        end else if (i_ctl.rd_en) begin
            r_dat_idx <= r_rd_idx;
            r_rd_idx  <= is_rem ? (r_rd_idx + AW'(1)) : (r_rd_idx - AW'(1));
        end
    end

    always_comb begin
        o_sts.is_rem   = is_rem;
        o_sts.empty    = (r_fill == '0);
        o_sts.full     = (r_fill >= CW'(CAPACITY));
        o_sts.rd_last  = is_rem ? (r_rd_idx == fill_m1) : (r_rd_idx == '0);
        o_sts.dat_last = is_rem ? (r_dat_idx == fill_m1) : (r_dat_idx == '0);
        o_sts.gt       = ($signed(r_rd_data) > $signed(r_val));
        o_sts.eq       = (r_rd_data == r_val);
        o_sts.found    = r_found;
    end

    assign o_fill = r_fill;

endmodule

`default_nettype wire

### design/sli_ctl.sv
// sli_ctl: controller state machine of the sorted list walk
// depends on sli_pkg
`default_nettype none

module sli_ctl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_out_free,
    input  wire sli_pkg::t_dp_sts i_sts,
    output sli_pkg::t_dp_ctl    o_ctl,
    output logic                o_in_ready,
    output logic                o_res_load,
    output sli_pkg::t_status    o_status
);

    sli_pkg::t_state  r_state;
    sli_pkg::t_state  n_state;
    logic             r_issue;
    logic             n_issue;
    sli_pkg::t_status r_status;
    sli_pkg::t_status n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sli_pkg::S_IDLE;
            r_issue  <= 1'b0;
            r_status <= sli_pkg::ST_INSERTED;
        end else begin
            r_state  <= n_state;
            r_issue  <= n_issue;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_issue    = r_issue;
        n_status   = r_status;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        o_res_load = 1'b0;
        unique case (r_state)
            sli_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = sli_pkg::S_START;
                end
            end
            sli_pkg::S_START: begin
                if (!i_sts.is_rem && i_sts.full) begin
                    n_status = sli_pkg::ST_FULL;
                    n_state  = sli_pkg::S_RESP;
                end else if (!i_sts.is_rem && i_sts.empty) begin
                    o_ctl.wr_en    = 1'b1;
                    o_ctl.wr_sel   = sli_pkg::WR_VAL_HEAD;
                    o_ctl.fill_inc = 1'b1;
                    n_status       = sli_pkg::ST_INSERTED;
                    n_state        = sli_pkg::S_RESP;
                end else if (i_sts.is_rem && i_sts.empty) begin
                    n_status = sli_pkg::ST_EMPTY;
                    n_state  = sli_pkg::S_RESP;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    n_issue     = !i_sts.rd_last;
                    n_state     = sli_pkg::S_SCAN;
                end
            end
            sli_pkg::S_SCAN: begin
                // read of the next entry overlaps the compare of the current one
                o_ctl.rd_en = r_issue;
                n_issue     = r_issue && !i_sts.rd_last;
                if (!i_sts.is_rem) begin
                    o_ctl.wr_en = 1'b1;
                    if (i_sts.gt) begin
                        o_ctl.wr_sel = sli_pkg::WR_SHIFT_UP;
                        if (i_sts.dat_last) begin
                            n_state = sli_pkg::S_HEAD;
                        end
                    end else begin
                        o_ctl.wr_sel   = sli_pkg::WR_VAL_UP;
                        o_ctl.fill_inc = 1'b1;
                        n_status       = sli_pkg::ST_INSERTED;
                        n_state        = sli_pkg::S_RESP;
                    end
                end else begin
                    if (i_sts.found) begin
                        o_ctl.wr_en  = 1'b1;
                        o_ctl.wr_sel = sli_pkg::WR_SHIFT_DN;
                    end else if (i_sts.eq) begin
                        o_ctl.set_found = 1'b1;
                    end
                    if (i_sts.dat_last) begin
                        if (i_sts.found || i_sts.eq) begin
                            o_ctl.fill_dec = 1'b1;
                            n_status       = sli_pkg::ST_REMOVED;
                        end else begin
                            n_status = sli_pkg::ST_NOTFOUND;
                        end
                        n_state = sli_pkg::S_RESP;
                    end
                end
            end
            sli_pkg::S_HEAD: begin
                o_ctl.wr_en    = 1'b1;
                o_ctl.wr_sel   = sli_pkg::WR_VAL_HEAD;
                o_ctl.fill_inc = 1'b1;
                n_status       = sli_pkg::ST_INSERTED;
                n_state        = sli_pkg::S_RESP;
            end
            sli_pkg::S_RESP: begin
                n_issue = 1'b0;
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = sli_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sli_pkg::S_IDLE;
            end
        endcase
    end

    assign o_status = r_status;

endmodule

`default_nettype wire

### design/sorted_list_insert_remove_top.sv
// sorted_list_insert_remove_top: bounded sorted list with insert and remove commands
// depends on sli_pkg, sli_ctl, sli_dp
//
// keeps up to CAPACITY signed 32-bit entries in ascending order, duplicates allowed.
// an insert word (tuser 0) places the value after every entry less than or equal to it;
// a remove word (tuser 1) deletes the first entry equal to the value. each input word
// yields one output word: tuser carries the status (0 inserted, 1 removed, 2 not found,
// 3 list empty, 4 list full) and tdata the entry count after the command, low 5 bits.
// the entries sit in a single memory with one write and one registered read port; a
// walk reads one entry a cycle while the previous entry is compared and moved. insert
// into a full list, remove from an empty list and insert into an empty list need no walk.
// a new word is taken once the previous result sits in the output register, even while
// that result still waits for the sink. no clearing pass is needed after reset.
`default_nettype none

module sorted_list_insert_remove_top #(
    parameter int CAPACITY = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input word
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,   // [31:0] value
    input  wire         i_s_axis_tuser,   // [0] cmd
    // result word
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [4:0] entry_count, [7:5] zero
    output logic [2:0]  o_m_axis_tuser    // [2:0] status
);

    localparam int CW = $clog2(CAPACITY + 1);

    sli_pkg::t_dp_ctl ctl;
    sli_pkg::t_dp_sts sts;
    sli_pkg::t_status res_status;
    logic             res_load;
    logic             out_free;
    logic [CW-1:0]    fill;

    // output register, parts the walk from the sink
    logic             r_o_tvalid;
    logic [2:0]       r_o_status;
    logic [4:0]       r_o_count;

    assign out_free = !r_o_tvalid || i_m_axis_tready;

    sli_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_in_ready (o_s_axis_tready),
        .o_res_load (res_load),
        .o_status   (res_status)
    );

    sli_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_cmd   (i_s_axis_tuser),
        .i_value (i_s_axis_tdata),
        .o_sts   (sts),
        .o_fill  (fill)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_tvalid <= 1'b0;
        end else if (res_load) begin
            r_o_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_tvalid <= 1'b0;
        end
    end

    // count is already updated when the result is loaded
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_o_status <= res_status;
            r_o_count  <= 5'(fill);
        end
    end

    assign o_m_axis_tvalid = r_o_tvalid;
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tdata  = {3'b000, r_o_count};

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench for sorted_list_insert_remove_top: insert and remove words against a local list model
// depends on sli_pkg and the sorted list rtl

module testbench;

    localparam int LIST_DEPTH = 16;
    localparam int CLK_PERIOD = 4;
    localparam int DRAIN_CYCLES = LIST_DEPTH + 8;

    // one command word as queued for the driver
    typedef struct {
        sli_pkg::t_cmd op;
        logic [31:0]   val;
    } t_list_cmd;

    // one result word as the list should report it
    typedef struct {
        sli_pkg::t_status st;
        logic [4:0]       count;
    } t_list_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [7:0]  m_tdata;
    wire  [2:0]  m_tuser;

    // commands waiting for the driver, outcomes waiting for the monitor
    t_list_cmd     cmd_backlog[$];
    t_list_outcome outcome_q[$];
    // values the generator believes are held, used to aim removes at real entries
    logic [31:0]   gen_held[$];

    // local copy of the list, updated as each command word is accepted
    logic signed [31:0] model_entries[LIST_DEPTH];
    int unsigned        model_fill = 0;

    // idle rates in percent, changed per phase
    int send_idle = 0;
    int recv_idle = 0;

    int mismatch_count = 0;
    int cmds_taken = 0;
    int results_seen = 0;
    int status_seen[5] = '{default: 0};

    sorted_list_insert_remove_top #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [31:0] value
        .i_s_axis_tuser  (s_tuser),   // [0] cmd
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [4:0] entry_count, [7:5] zero
        .o_m_axis_tuser  (m_tuser)    // [2:0] status
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // applies one command to the local list and returns the status it should give
    function automatic sli_pkg::t_status list_apply(sli_pkg::t_cmd op,
                                                    logic signed [31:0] v);
        int unsigned pos;
        int unsigned i;
        pos = 0;
        if (op == sli_pkg::CMD_INSERT) begin
            if (model_fill >= LIST_DEPTH)
                return sli_pkg::ST_FULL;
            // new value goes after every entry less than or equal to it
            while (pos < model_fill && model_entries[pos] <= v)
                pos++;
            for (i = model_fill; i > pos; i--)
                model_entries[i] = model_entries[i - 1];
            model_entries[pos] = v;
            model_fill++;
            return sli_pkg::ST_INSERTED;
        end
        if (model_fill == 0)
            return sli_pkg::ST_EMPTY;
        while (pos < model_fill && model_entries[pos] != v)
            pos++;
        if (pos >= model_fill)
            return sli_pkg::ST_NOTFOUND;
        // close the gap left by the first equal entry
        for (i = pos; i + 1 < model_fill; i++)
            model_entries[i] = model_entries[i + 1];
        model_fill--;
        return sli_pkg::ST_REMOVED;
    endfunction

    // driver: presents the next command word, holding it until the block takes it
    always @(posedge i_clk) begin
        t_list_cmd nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                t_list_outcome o;
                o.st = list_apply(sli_pkg::t_cmd'(s_tuser), s_tdata);
                o.count = model_fill[4:0];
                outcome_q.push_back(o);
                cmds_taken++;
            end
            // a word may only change once the current one has gone or none is shown
            if (!s_tvalid || s_tready) begin
                if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle) begin
                    nxt = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.val;
                    s_tuser  <= nxt.op;
                end else begin
                    // idle cycle: data lines carry noise the block must ignore
                    s_tvalid <= 1'b0;
                    s_tdata  <= $urandom;
                    s_tuser  <= 1'($urandom_range(1));
                end
            end
        end
    end

    // sink side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // monitor: every accepted result word is checked against the oldest outcome
    always @(posedge i_clk) begin
        t_list_outcome exp_o;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser < 3'd5)
                status_seen[m_tuser]++;
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result word, status %0d count %0d",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                exp_o = outcome_q.pop_front();
                if (m_tuser !== exp_o.st) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, exp_o.st, m_tuser);
                    mismatch_count++;
                end
                // pad bits above the count are part of the word and must be zero
                if (m_tdata !== {3'b000, exp_o.count}) begin
                    $display("%0t: entry count mismatch, expected %0d actual %0d",
                             $time, {3'b000, exp_o.count}, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic push_cmd(input sli_pkg::t_cmd op, input logic [31:0] v);
        t_list_cmd c;
        c.op = op;
        c.val = v;
        cmd_backlog.push_back(c);
    endtask

    // sender holds off until nothing is queued, shown or outstanding
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || s_tvalid || outcome_q.size() != 0)
            @(negedge i_clk);
    endtask

    // alternating runs of inserts and removes so the list swings between empty and full;
    // most removes target values believed held, the rest are misses
    task automatic queue_random(input int n);
        int left;
        int run;
        int pick;
        logic [31:0] v;
        sli_pkg::t_cmd op;
        left = n;
        op = sli_pkg::CMD_INSERT;
        while (left > 0) begin
            run = $urandom_range(1, 20);
            if (run > left)
                run = left;
            repeat (run) begin
                if (op == sli_pkg::CMD_INSERT) begin
                    case ($urandom_range(9))
                        0: begin
                            case ($urandom_range(3))
                                0: v = 32'h8000_0000;
                                1: v = 32'h7fff_ffff;
                                2: v = 32'h0000_0000;
                                default: v = 32'hffff_ffff;
                            endcase
                        end
                        1, 2, 3: v = $urandom_range(7) - 4;   // small values, many duplicates
                        default: v = $urandom;
                    endcase
                    if (gen_held.size() < LIST_DEPTH)
                        gen_held.push_back(v);
                end else if (gen_held.size() > 0 && $urandom_range(9) < 8) begin
                    pick = $urandom_range(gen_held.size() - 1);
                    v = gen_held[pick];
                    gen_held.delete(pick);
                end else begin
                    v = $urandom;
                end
                push_cmd(op, v);
            end
            left -= run;
            op = (op == sli_pkg::CMD_INSERT) ? sli_pkg::CMD_REMOVE : sli_pkg::CMD_INSERT;
        end
    endtask

    // stimulus and run control; reset is released on a rising edge, later changes on the falling edge
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // phase one: sender rarely idle, sink mostly stalled
        send_idle = 11;
        recv_idle = 85;

        // directed: remove from an empty list first
        push_cmd(sli_pkg::CMD_REMOVE, 32'h0000_0005);
        // fill to capacity with extremes and duplicates
        push_cmd(sli_pkg::CMD_INSERT, 32'h7fff_ffff);
        push_cmd(sli_pkg::CMD_INSERT, 32'h8000_0000);
        push_cmd(sli_pkg::CMD_INSERT, 32'h0000_0000);
        push_cmd(sli_pkg::CMD_INSERT, 32'h0000_0000);
        push_cmd(sli_pkg::CMD_INSERT, 32'hffff_ffff);
        push_cmd(sli_pkg::CMD_INSERT, 32'h0000_0001);
        push_cmd(sli_pkg::CMD_INSERT, 32'h7fff_ffff);
        push_cmd(sli_pkg::CMD_INSERT, 32'h8000_0000);
        for (int k = 0; k < LIST_DEPTH - 8; k++)
            push_cmd(sli_pkg::CMD_INSERT, $urandom);
        // insert into a full list is refused
        push_cmd(sli_pkg::CMD_INSERT, 32'h0000_0002);
        // absent value, one duplicate, and both ends
        push_cmd(sli_pkg::CMD_REMOVE, 32'h1234_5678);
        push_cmd(sli_pkg::CMD_REMOVE, 32'h0000_0000);
        push_cmd(sli_pkg::CMD_REMOVE, 32'h8000_0000);
        push_cmd(sli_pkg::CMD_REMOVE, 32'h7fff_ffff);

        // let every directed result arrive before going on
        wait_drained();
        // the directed words leave the local list holding values the generator never saw
        gen_held.delete();
        for (int k = 0; k < model_fill; k++)
            gen_held.push_back(model_entries[k]);

        queue_random(330);
        wait_drained();

        // phase two: sender mostly idle, sink rarely stalled
        send_idle = 85;
        recv_idle = 11;
        queue_random(330);
        wait_drained();

        // phase three: back to back in both directions
        send_idle = 0;
        recv_idle = 0;
        queue_random(340);
        wait_drained();

        // room for any stray word still on its way out
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d commands, %0d results: inserted %0d, removed %0d,",
                 cmds_taken, results_seen, status_seen[sli_pkg::ST_INSERTED],
                 status_seen[sli_pkg::ST_REMOVED]);
        $display("not found %0d, empty %0d, full %0d, under three idle patterns",
                 status_seen[sli_pkg::ST_NOTFOUND], status_seen[sli_pkg::ST_EMPTY],
                 status_seen[sli_pkg::ST_FULL]);
        if (mismatch_count == 0 && outcome_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", outcome_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
